// ===== design/kqf_pkg.sv =====
// Package for the Kuwahara quadrant filter: default sizes, reset values, luma weights,
// register indexes and the sequencer state type. Used by the top level and the testbench.
package kqf_pkg;

	localparam int MAX_RADIUS_DEF = 12;
	localparam int MAX_WIDTH_DEF  = 1024;

	// luma weights, units of 1/256
	localparam int LUMA_WR = 77;
	localparam int LUMA_WG = 150;
	localparam int LUMA_WB = 29;

	localparam logic [1:0] REG_RADIUS    = 2'd0;
	localparam logic [1:0] REG_ROW_WIDTH = 2'd1;
	localparam logic [1:0] REG_GRAY_MODE = 2'd2;

	localparam logic [3:0]  RADIUS_RST    = 4'd3;
	localparam logic [10:0] ROW_WIDTH_RST = 11'd640;
	localparam logic [11:0] ROW_CNT_MAX   = 12'd4095;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_PAD_RD,
		ST_PAD_WR,
		ST_STORE,
		ST_PLAN,
		ST_QSTART,
		ST_READ,
		ST_DRAIN,
		ST_KEY1,
		ST_KEY2,
		ST_KEY3,
		ST_ALPHA_RD,
		ST_ALPHA_WT,
		ST_DIV_LD,
		ST_DIV,
		ST_EMIT,
		ST_FINISH
	} kqf_state_t;

endpackage

// ===== design/kqf_ram.sv =====
// Generic single-clock RAM: one write port, one read port, registered read.
// Self-contained, no package needed.
module kqf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== design/kuwahara_quadrant_filter.sv =====
// Kuwahara quadrant filter, top level: line store, read sequencer, shared
// accumulate / key / divide datapath. Depends on kqf_pkg and kqf_ram.
//
//  channel  | handshake               | payload
//  ---------+-------------------------+-------------------------------------------
//  s_ (in)  | s_tvalid / s_tready     | s_tdata: red, green, blue, alpha
//           |                         | s_tuser: mode, frame_start
//  m_ (out) | m_tvalid / m_tready     | m_tdata: red, green, blue, alpha, quadrant
//           |                         | m_tlast: last result of this input word
//  cfg      | cfg_wr_en               | cfg_addr: radius, row_width, gray_mode
//
// An input word with no result steps through idle, store, plan and finish; a
// padding word below row zero goes through idle, pad read, pad write, plan and
// finish. Each result adds the quadrant reads through the single line store read
// port (one pixel per cycle) and the shared bit-serial divider. s_tready is high
// only while the sequencer is idle. A finished result sits in the output register;
// the next input word is taken while it waits, and the sequencer holds only when it
// has a new result and that register is full. Reset clears control state and loads
// the configuration defaults; payload registers and the line store are not cleared.
module kuwahara_quadrant_filter import kqf_pkg::*; #(
	parameter int MAX_RADIUS = MAX_RADIUS_DEF,
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [7:0] in_red, [15:8] in_green, [23:16] in_blue, [31:24] in_alpha
	input  logic [1:0]  s_tuser,   // [0] mode, [1] frame_start
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [7:0] out_red, [15:8] out_green, [23:16] out_blue,
	                               // [31:24] out_alpha, [33:32] chosen_quadrant, rest zero
	output logic        m_tlast,   // burst_last
	input  logic        cfg_wr_en,
	input  logic [1:0]  cfg_addr,
	input  logic [10:0] cfg_wdata
);

	localparam int RW    = $clog2(MAX_RADIUS + 1);
	localparam int P_MAX = 2 * MAX_RADIUS + 1;
	localparam int SLW   = $clog2(P_MAX);
	localparam int COLW  = $clog2(MAX_WIDTH);
	localparam int CW    = COLW + 1;
	localparam int XW    = ((CW > RW) ? CW : RW) + 2;
	localparam int NMAX  = (MAX_RADIUS + 1) * (MAX_RADIUS + 1);
	localparam int NW    = $clog2(NMAX + 1);
	localparam int SW    = NW + 8;
	localparam int LSW   = NW + 16;
	localparam int SQW   = NW + 32;
	localparam int KW    = 2 * NW + 32;
	localparam int DEPTH = P_MAX * MAX_WIDTH;
	localparam int AW    = $clog2(DEPTH);
	localparam int DCW   = $clog2(SW);

	// step back d rows from slot cur, modulo p
	function automatic logic [SLW-1:0] slot_back(logic [SLW-1:0] cur, logic [SLW-1:0] d,
		logic [SLW:0] p);
		logic [SLW:0] t;
		t = (cur >= d) ? ({1'b0, cur} - {1'b0, d}) : ({1'b0, cur} + p - {1'b0, d});
		return t[SLW-1:0];
	endfunction

	function automatic logic [AW-1:0] mem_addr(logic [SLW-1:0] s, logic [COLW-1:0] col);
		return AW'(AW'(s) * AW'(MAX_WIDTH)) + AW'(col);
	endfunction

	// configuration
	logic [3:0]  radius_q;
	logic [10:0] row_width_q;
	logic        gray_q;

	// frame position
	logic [COLW-1:0] col_cnt_q;
	logic [11:0]     row_cnt_q;
	logic [SLW-1:0]  cur_slot_q;

	// per-word context
	logic [RW-1:0]   r_q;
	logic [CW-1:0]   w_q;
	logic [SLW:0]    p_q;
	logic [SLW-1:0]  slot_q;
	logic [COLW-1:0] c_q;
	logic [11:0]     yin_q;
	logic [NW-1:0]   n_q;
	logic [31:0]     px_q;

	// result loop
	logic [COLW-1:0] x_q, xe_q;
	logic [1:0]      quad_q;
	logic [RW-1:0]   dy_q, dx_q;

	// accumulate pipeline
	logic            v_s1, v_s2, v_s3;
	logic [15:0]     lum_s2;
	logic [7:0]      r_s2, g_s2, b_s2, r_s3, g_s3, b_s3;
	logic [31:0]     sq_s3;
	logic [SW-1:0]   sr_q, sg_q, sb_q;
	logic [SQW-1:0]  ssq_q;

	// key and choice
	logic [LSW-1:0]  sl_q;
	logic [KW-1:0]   nsq_q, sl2_q, best_key_q;
	logic [1:0]      best_quad_q;
	logic [SW-1:0]   best_r_q, best_g_q, best_b_q;
	logic [7:0]      alpha_q;

	// divider
	logic [SW-1:0]   div_quo_q;
	logic [NW-1:0]   div_rem_q;
	logic [DCW-1:0]  div_cnt_q;
	logic [1:0]      ch_q;
	logic [7:0]      mean_r_q, mean_g_q, mean_b_q;

	// output register
	logic            out_valid_q;
	logic [39:0]     out_data_q;
	logic            out_last_q;

	kqf_state_t state_q, state_d;

	// RAM ports
	logic            ram_we;
	logic [AW-1:0]   ram_waddr, ram_raddr;
	logic [31:0]     ram_wdata, ram_rdata;

	kqf_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_line_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// ---------------------------------------------------------------------
	// Effective settings for an accepted word: clamp radius, width and column, zero
	// the position on frame_start, restart the slot index if the radius shrank under it.
	// ---------------------------------------------------------------------
	logic [RW-1:0]   r_eff;
	logic [RW:0]     rp1;
	logic [CW-1:0]   w_eff;
	logic [SLW:0]    p_eff;
	logic [SLW-1:0]  slot_eff;
	logic [11:0]     row_eff;
	logic [COLW-1:0] col_raw, c_eff;
	logic            in_accept;

	always_comb begin
		if (radius_q == 4'd0) begin
			r_eff = RW'(1);
		end else if (32'(radius_q) > 32'(MAX_RADIUS)) begin
			r_eff = RW'(MAX_RADIUS);
		end else begin
			r_eff = RW'(radius_q);
		end
		rp1 = {1'b0, r_eff} + (RW+1)'(1);
		if (row_width_q == 11'd0) begin
			w_eff = CW'(1);
		end else if (32'(row_width_q) > 32'(MAX_WIDTH)) begin
			w_eff = CW'(MAX_WIDTH);
		end else begin
			w_eff = CW'(row_width_q);
		end
		p_eff    = (SLW+1)'({r_eff, 1'b1});
		slot_eff = ({1'b0, cur_slot_q} >= p_eff) ? '0 : cur_slot_q;
		row_eff  = s_tuser[1] ? 12'd0 : row_cnt_q;
		col_raw  = s_tuser[1] ? '0 : col_cnt_q;
		c_eff    = (CW'(col_raw) > w_eff - CW'(1)) ? COLW'(w_eff - CW'(1)) : col_raw;
	end

	assign in_accept = s_tvalid && s_tready;

	// ---------------------------------------------------------------------
	// Quadrant read address: clamp the row at the top edge and the column
	// at both side edges.
	// ---------------------------------------------------------------------
	logic [RW:0]          row_base;
	logic [SLW-1:0]       d_row;
	logic signed [XW-1:0] col_s, wm1_s;
	logic [COLW-1:0]      col_rd;
	logic [AW-1:0]        quad_addr;

	always_comb begin
		row_base = (quad_q[1] ? {1'b0, r_q} : {r_q, 1'b0}) - (RW+1)'(dy_q);
		d_row    = (yin_q < 12'(row_base)) ? SLW'(yin_q) : SLW'(row_base);
		wm1_s    = signed'(XW'(w_q) - XW'(1));
		col_s    = signed'(XW'(x_q)) - (quad_q[0] ? '0 : signed'(XW'(r_q)))
		           + signed'(XW'(dx_q));
		if (col_s < 0) begin
			col_rd = '0;
		end else if (col_s > wm1_s) begin
			col_rd = COLW'(wm1_s);
		end else begin
			col_rd = COLW'(col_s);
		end
		quad_addr = mem_addr(slot_back(slot_q, d_row, p_q), col_rd);
	end

	always_comb begin
		priority case (state_q)
			ST_PAD_RD:   ram_raddr = mem_addr(slot_back(slot_q, SLW'(1), p_q), c_q);
			ST_ALPHA_RD: ram_raddr = mem_addr(slot_back(slot_q, SLW'(r_q), p_q), x_q);
			default:     ram_raddr = quad_addr;
		endcase
	end

	assign ram_we    = (state_q == ST_STORE) || (state_q == ST_PAD_WR);
	assign ram_waddr = mem_addr(slot_q, c_q);
	assign ram_wdata = (state_q == ST_PAD_WR) ? ram_rdata : px_q;

	// ---------------------------------------------------------------------
	// Sequencer
	// ---------------------------------------------------------------------
	logic            row_last, emit_hit, read_last, out_free, div_ge;
	logic [NW:0]     div_t;
	logic [NW-1:0]   div_rem_nxt;
	logic [SW-1:0]   div_quo_nxt;
	logic [KW-1:0]   key;

	always_comb begin
		row_last    = (CW'(c_q) == w_q - CW'(1));
		emit_hit    = (yin_q >= 12'(r_q)) && (row_last || (XW'(c_q) >= XW'(r_q)));
		read_last   = (dx_q == r_q) && (dy_q == r_q);
		out_free    = !out_valid_q || m_tready;
		div_t       = {div_rem_q, div_quo_q[SW-1]};
		div_ge      = (div_t >= {1'b0, n_q});
		div_rem_nxt = div_ge ? NW'(div_t - {1'b0, n_q}) : NW'(div_t);
		div_quo_nxt = {div_quo_q[SW-2:0], div_ge};
		key         = nsq_q - sl2_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = (s_tuser[0] && (row_eff != 12'd0)) ? ST_PAD_RD : ST_STORE;
				end
			end
			ST_PAD_RD:   state_d = ST_PAD_WR;
			ST_PAD_WR:   state_d = ST_PLAN;
			ST_STORE:    state_d = ST_PLAN;
			ST_PLAN:     state_d = emit_hit ? ST_QSTART : ST_FINISH;
			ST_QSTART:   state_d = ST_READ;
			ST_READ:     state_d = read_last ? ST_DRAIN : ST_READ;
			ST_DRAIN:    state_d = (!v_s1 && !v_s2 && !v_s3) ? ST_KEY1 : ST_DRAIN;
			ST_KEY1:     state_d = ST_KEY2;
			ST_KEY2:     state_d = ST_KEY3;
			ST_KEY3:     state_d = (quad_q == 2'd3) ? ST_ALPHA_RD : ST_QSTART;
			ST_ALPHA_RD: state_d = ST_ALPHA_WT;
			ST_ALPHA_WT: state_d = ST_DIV_LD;
			ST_DIV_LD:   state_d = ST_DIV;
			ST_DIV: begin
				if (div_cnt_q == DCW'(SW - 1)) begin
					state_d = (ch_q == 2'd2) ? ST_EMIT : ST_DIV_LD;
				end
			end
			ST_EMIT: begin
				if (out_free) begin
					state_d = (x_q == xe_q) ? ST_FINISH : ST_QSTART;
				end
			end
			ST_FINISH:   state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// ---------------------------------------------------------------------
	// Configuration and frame position
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q    <= RADIUS_RST;
			row_width_q <= ROW_WIDTH_RST;
			gray_q      <= 1'b0;
		end else if (cfg_wr_en) begin
			unique case (cfg_addr)
				REG_RADIUS:    radius_q    <= cfg_wdata[3:0];
				REG_ROW_WIDTH: row_width_q <= cfg_wdata;
				REG_GRAY_MODE: gray_q      <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_cnt_q  <= '0;
			row_cnt_q  <= '0;
			cur_slot_q <= '0;
		end else if (state_q == ST_FINISH) begin
			if (row_last) begin
				col_cnt_q  <= '0;
				row_cnt_q  <= (yin_q != ROW_CNT_MAX) ? yin_q + 12'd1 : yin_q;
				cur_slot_q <= ({1'b0, slot_q} + (SLW+1)'(1) == p_q) ? '0 : slot_q + SLW'(1);
			end else begin
				col_cnt_q  <= c_q + COLW'(1);
				row_cnt_q  <= yin_q;
				cur_slot_q <= slot_q;
			end
		end
	end

	// ---------------------------------------------------------------------
	// Per-word context, loop counters and datapath
	// ---------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			r_q   <= '0;
			w_q   <= '0;
			p_q   <= '0;
			slot_q <= '0;
			c_q   <= '0;
			yin_q <= '0;
			n_q   <= '0;
			x_q   <= '0;
			xe_q  <= '0;
			quad_q <= '0;
			dy_q  <= '0;
			dx_q  <= '0;
			ch_q  <= '0;
			div_cnt_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						r_q    <= r_eff;
						w_q    <= w_eff;
						p_q    <= p_eff;
						slot_q <= slot_eff;
						c_q    <= c_eff;
						yin_q  <= row_eff;
						n_q    <= NW'(NW'(rp1) * NW'(rp1));
					end
				end
				ST_PLAN: begin
					// result columns for this word: the lagging column, or the
					// whole rest of the output row on the last input column
					if (row_last) begin
						x_q  <= (XW'(c_q) >= XW'(r_q)) ? c_q - COLW'(r_q) : '0;
						xe_q <= c_q;
					end else begin
						x_q  <= c_q - COLW'(r_q);
						xe_q <= c_q - COLW'(r_q);
					end
					quad_q <= '0;
				end
				ST_QSTART: begin
					dy_q <= '0;
					dx_q <= '0;
				end
				ST_READ: begin
					if (dx_q == r_q) begin
						dx_q <= '0;
						if (dy_q != r_q) begin
							dy_q <= dy_q + RW'(1);
						end
					end else begin
						dx_q <= dx_q + RW'(1);
					end
				end
				ST_KEY3: begin
					if (quad_q != 2'd3) begin
						quad_q <= quad_q + 2'd1;
					end
					ch_q <= '0;
				end
				ST_DIV_LD: begin
					div_cnt_q <= '0;
				end
				ST_DIV: begin
					div_cnt_q <= div_cnt_q + DCW'(1);
					if (div_cnt_q == DCW'(SW - 1)) begin
						ch_q <= ch_q + 2'd1;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						x_q    <= x_q + COLW'(1);
						quad_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (in_accept) begin
			px_q <= (s_tuser[0]) ? 32'd0 : s_tdata;
		end
		if (state_q == ST_QSTART) begin
			sr_q  <= '0;
			sg_q  <= '0;
			sb_q  <= '0;
			ssq_q <= '0;
		end else if (v_s3) begin
			sr_q  <= sr_q + SW'(r_s3);
			sg_q  <= sg_q + SW'(g_s3);
			sb_q  <= sb_q + SW'(b_s3);
			ssq_q <= ssq_q + SQW'(sq_s3);
		end
		// luma, then its square, one register apart
		r_s2   <= ram_rdata[7:0];
		g_s2   <= ram_rdata[15:8];
		b_s2   <= ram_rdata[23:16];
		lum_s2 <= gray_q ? 16'(ram_rdata[7:0])
		          : 16'(16'(LUMA_WR) * 16'(ram_rdata[7:0]))
		          + 16'(16'(LUMA_WG) * 16'(ram_rdata[15:8]))
		          + 16'(16'(LUMA_WB) * 16'(ram_rdata[23:16]));
		r_s3   <= r_s2;
		g_s3   <= g_s2;
		b_s3   <= b_s2;
		sq_s3  <= 32'(lum_s2) * 32'(lum_s2);

		if (state_q == ST_KEY1) begin
			sl_q  <= gray_q ? LSW'(sr_q)
			         : LSW'(LSW'(LUMA_WR) * LSW'(sr_q)) + LSW'(LSW'(LUMA_WG) * LSW'(sg_q))
			         + LSW'(LSW'(LUMA_WB) * LSW'(sb_q));
			nsq_q <= KW'(n_q) * KW'(ssq_q);
		end
		if (state_q == ST_KEY2) begin
			sl2_q <= KW'(sl_q) * KW'(sl_q);
		end
		// strict compare: ties keep the earlier quadrant
		if ((state_q == ST_KEY3) && ((quad_q == 2'd0) || (key < best_key_q))) begin
			best_key_q  <= key;
			best_quad_q <= quad_q;
			best_r_q    <= sr_q;
			best_g_q    <= sg_q;
			best_b_q    <= sb_q;
		end
		if (state_q == ST_ALPHA_WT) begin
			alpha_q <= ram_rdata[31:24];
		end
		if (state_q == ST_DIV_LD) begin
			div_rem_q <= '0;
			unique case (ch_q)
				2'd0:    div_quo_q <= best_r_q;
				2'd1:    div_quo_q <= best_g_q;
				default: div_quo_q <= best_b_q;
			endcase
		end else if (state_q == ST_DIV) begin
			div_rem_q <= div_rem_nxt;
			div_quo_q <= div_quo_nxt;
			if (div_cnt_q == DCW'(SW - 1)) begin
				unique case (ch_q)
					2'd0:    mean_r_q <= div_quo_nxt[7:0];
					2'd1:    mean_g_q <= div_quo_nxt[7:0];
					default: mean_b_q <= div_quo_nxt[7:0];
				endcase
			end
		end
		if ((state_q == ST_EMIT) && out_free) begin
			out_data_q <= {6'd0, best_quad_q, alpha_q,
			               gray_q ? 8'd0 : mean_b_q,
			               gray_q ? 8'd0 : mean_g_q,
			               mean_r_q};
			out_last_q <= (x_q == xe_q);
		end
	end

	// read pipeline valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= (state_q == ST_READ);
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// output register: load a result, drop it once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_EMIT) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

endmodule

// ===== verif/kuwahara_quadrant_filter_test.sv =====
// Self-checking testbench for the Kuwahara quadrant filter: streams pixel frames,
// predicts every filtered pixel, checks each output word. Needs kqf_pkg and the RTL.
module kuwahara_quadrant_filter_test;
	import kqf_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CYCLE_LIMIT = 3000000;
	localparam int SETTLE      = 60;     // margin for a word with no result to finish
	localparam int NSLOT       = 2 * MAX_RADIUS_DEF + 1;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic [1:0] quad;
		logic       last;
	} filt_px_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;   // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha
	logic [1:0]  s_tuser;   // [0] mode, [1] frame_start
	logic        m_tvalid;
	logic        m_tready;
	logic [39:0] m_tdata;   // [7:0] red, [15:8] green, [23:16] blue, [31:24] alpha, [33:32] quad
	logic        m_tlast;   // last result of the input word
	logic        cfg_wr_en;
	logic [1:0]  cfg_addr;
	logic [10:0] cfg_wdata;

	kuwahara_quadrant_filter dut (.*);

	// predictor state
	logic [31:0] pix_store [NSLOT][MAX_WIDTH_DEF];
	logic [3:0]  p_radius;
	logic [10:0] p_width;
	logic        p_gray;
	int          p_col, p_row, p_slot;
	filt_px_t    pending_px[$];

	int  errors;
	int  words_sent;
	int  cycles;
	bit  tx_quiet, rx_quiet;   // no idling on that side
	int  rx_hold;              // long receiver hold-off, in cycles

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		arst_n    <= 1'b0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= '0;
		m_tready  <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_addr  <= REG_RADIUS;
		cfg_wdata <= '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
	end

	// Filter one output pixel from the four quadrants around column x.
	function automatic filt_px_t quad_filter(int x, int yin, int r, int w, int p);
		filt_px_t res;
		longint unsigned n, sr, sg, sb, sq, sl, lum, key, best_key;
		longint unsigned br, bg, bb;
		int x0, y0, ry, col, sl_idx;
		logic [31:0] v;
		n = (r + 1) * (r + 1);
		best_key = 0; br = 0; bg = 0; bb = 0;
		res = '0;
		for (int q = 0; q < 4; q++) begin
			x0 = q[0] ? x : x - r;
			y0 = (q < 2) ? yin - 2 * r : yin - r;
			sr = 0; sg = 0; sb = 0; sq = 0;
			for (int dy = 0; dy <= r; dy++) begin
				ry = y0 + dy;
				if (ry < 0) ry = 0;
				sl_idx = (p_slot + p - (yin - ry)) % p;
				for (int dx = 0; dx <= r; dx++) begin
					col = x0 + dx;
					if (col < 0) col = 0;
					if (col > w - 1) col = w - 1;
					v = pix_store[sl_idx][col];
					sr += v[7:0]; sg += v[15:8]; sb += v[23:16];
					lum = p_gray ? v[7:0] : LUMA_WR * v[7:0] + LUMA_WG * v[15:8] + LUMA_WB * v[23:16];
					sq += lum * lum;
				end
			end
			sl = p_gray ? sr : LUMA_WR * sr + LUMA_WG * sg + LUMA_WB * sb;
			key = n * sq - sl * sl;
			// ties keep the earlier quadrant
			if (q == 0 || key < best_key) begin
				best_key = key; res.quad = q[1:0];
				br = sr; bg = sg; bb = sb;
			end
		end
		res.red   = 8'(br / n);
		res.green = p_gray ? 8'd0 : 8'(bg / n);
		res.blue  = p_gray ? 8'd0 : 8'(bb / n);
		res.alpha = pix_store[(p_slot + p - r) % p][x][31:24];
		return res;
	endfunction

	// Advance the predictor by one accepted word and queue its filtered pixels.
	function automatic void filter_word(logic mode, logic fs, logic [31:0] px);
		int r, w, p, c, xs, xe;
		logic [31:0] v;
		filt_px_t res;
		r = (p_radius == 0) ? 1 : (p_radius > MAX_RADIUS_DEF) ? MAX_RADIUS_DEF : p_radius;
		w = (p_width == 0) ? 1 : (p_width > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : p_width;
		p = 2 * r + 1;
		if (p_slot >= p) p_slot = 0;
		if (fs) begin
			p_col = 0;
			p_row = 0;
		end
		c = (p_col > w - 1) ? w - 1 : p_col;
		if (!mode) v = px;
		else if (p_row == 0) v = '0;
		else v = pix_store[(p_slot + p - 1) % p][c];   // replicate the row above
		pix_store[p_slot][c] = v;
		if (p_row >= r && (c == w - 1 || c >= r)) begin
			xs = (c >= r) ? c - r : 0;
			xe = (c == w - 1) ? c : c - r;
			for (int x = xs; x <= xe; x++) begin
				res = quad_filter(x, p_row, r, w, p);
				res.last = (x == xe);
				pending_px.push_back(res);
			end
		end
		if (c == w - 1) begin
			p_col = 0;
			if (p_row < ROW_CNT_MAX) p_row++;
			p_slot = (p_slot + 1) % p;
		end else begin
			p_col = c + 1;
		end
	endfunction

	task automatic check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name, exp_v, act_v);
			errors++;
		end
	endtask

	// Output side: random stalls, long hold-off on request, check each word.
	initial begin
		filt_px_t e;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				if (pending_px.size() == 0) begin
					$display("%0t: unexpected word, expected none, actual %h last %b",
						$realtime, m_tdata, m_tlast);
					errors++;
				end else begin
					e = pending_px.pop_front();
					check_field("red", e.red, m_tdata[7:0]);
					check_field("green", e.green, m_tdata[15:8]);
					check_field("blue", e.blue, m_tdata[23:16]);
					check_field("alpha", e.alpha, m_tdata[31:24]);
					check_field("quadrant", 8'(e.quad), 8'(m_tdata[33:32]));
					check_field("padding", 8'd0, 8'(m_tdata[39:34]));
					check_field("last", 8'(e.last), 8'(m_tlast));
				end
			end
			if (rx_hold > 0) begin
				rx_hold--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= rx_quiet || ($urandom_range(99) >= 20);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Offer one word, wait for the handshake, then update the predictor.
	task automatic send_word(logic mode, logic fs, logic [31:0] px);
		if (!tx_quiet && $urandom_range(99) < 20) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= px;
		s_tuser  <= {fs, mode};
		do @(posedge clk); while (!s_tready);
		filter_word(mode, fs, px);
		words_sent++;
	endtask

	// Drop valid and hold until every expected word has come out.
	task automatic drain();
		s_tvalid <= 1'b0;
		while (pending_px.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// Write all three registers; the block is idle here.
	task automatic set_config(logic [3:0] r, logic [10:0] w, logic g);
		cfg_wr_en <= 1'b1;
		cfg_addr  <= REG_RADIUS;    cfg_wdata <= 11'(r);
		@(posedge clk);
		p_radius = r;
		cfg_addr  <= REG_ROW_WIDTH; cfg_wdata <= w;
		@(posedge clk);
		p_width = w;
		cfg_addr  <= REG_GRAY_MODE; cfg_wdata <= 11'(g);
		@(posedge clk);
		p_gray = g;
		cfg_wr_en <= 1'b0;
	endtask

	// One frame: real rows of pixels, then the padding rows at the bottom.
	// noise mixes stray padding words into the real rows.
	task automatic send_frame(int w, int rows, int pad_rows, int noise);
		logic [31:0] px;
		for (int y = 0; y < rows + pad_rows; y++)
			for (int x = 0; x < w; x++) begin
				px = $urandom;
				if ($urandom_range(3) == 0) px = {px[31:24], {3{px[7:0]}}};  // flat areas
				send_word(y >= rows || $urandom_range(99) < noise, x == 0 && y == 0, px);
			end
	endtask

	task automatic test_directed();
		logic [31:0] pat [9] = '{32'hFF_FFFFFF, 32'h00_000000, 32'hFF_FFFFFF,
			32'h00_000000, 32'h80_FF00FF, 32'h00_000000, 32'hFF_FFFFFF, 32'h00_000000,
			32'h7F_00FF00};
		set_config(4'd1, 11'd3, 1'b0);
		for (int i = 0; i < 9; i++) send_word(1'b0, i == 0, pat[i]);
		for (int i = 0; i < 3; i++) send_word(1'b1, 1'b0, '0);
		drain();
		// gray mode, frame opening with a padding word in row zero
		set_config(4'd1, 11'd2, 1'b1);
		send_word(1'b1, 1'b1, 32'hFFFFFFFF);
		send_word(1'b0, 1'b0, 32'h00_0000FF);
		send_word(1'b0, 1'b0, 32'hFF_FFFF00);
		send_word(1'b0, 1'b0, 32'hAA_55AA55);
		send_word(1'b1, 1'b0, '0);
		send_word(1'b1, 1'b0, '0);
		drain();
	endtask

	// Radius above the limit, width zero: one column, tallest quadrants; then radius zero, width above the limit.
	task automatic test_radius_limits();
		set_config(4'd15, 11'd0, 1'b0);
		send_frame(1, 13, 12, 0);
		drain();
		set_config(4'd0, 11'd2047, 1'b0);
		send_frame(4, 1, 0, 0);   // partial row at the widest setting
		drain();
	endtask

	// Width shrinks mid-row: the column counter lands past the new last column.
	task automatic test_width_shrink();
		set_config(4'd1, 11'd8, 1'b0);
		send_frame(3, 1, 0, 0);
		drain();
		set_config(4'd1, 11'd2, 1'b0);
		send_word(1'b0, 1'b0, $urandom);
		send_frame(2, 1, 0, 0);
		send_word(1'b0, 1'b0, $urandom);
		send_word(1'b0, 1'b0, $urandom);
		send_word(1'b1, 1'b0, '0);
		send_word(1'b1, 1'b0, '0);
		drain();
	endtask

	// Long output hold-off while input keeps coming; the block must stall.
	task automatic test_backpressure();
		set_config(4'd2, 11'd5, 1'b0);
		rx_hold = 3000;
		send_frame(5, 4, 2, 0);
		drain();
	endtask

	// Random frames; a few are cut short, a stretch runs with no idling.
	task automatic test_random_frames();
		int r, w, rows;
		int start = words_sent;
		while (words_sent - start < 170) begin
			r = ($urandom_range(7) == 0) ? $urandom_range(5, 6) : $urandom_range(1, 3);
			w = $urandom_range(1, 8);
			rows = r + $urandom_range(1, 3);
			tx_quiet = (words_sent - start >= 60 && words_sent - start < 120);
			rx_quiet = tx_quiet;
			set_config(4'(r), 11'(w), 1'($urandom_range(1)));
			if ($urandom_range(5) == 0)
				send_frame(w, $urandom_range(1, rows), 0, 10);   // broken frame
			else
				send_frame(w, rows, r, 5);
			drain();
		end
		tx_quiet = 0;
		rx_quiet = 0;
	endtask

	initial begin
		errors = 0; words_sent = 0; cycles = 0;
		tx_quiet = 0; rx_quiet = 0; rx_hold = 0;
		p_radius = RADIUS_RST; p_width = ROW_WIDTH_RST; p_gray = 1'b0;
		p_col = 0; p_row = 0; p_slot = 0;
		@(posedge arst_n);
		@(posedge clk);
		test_directed();
		test_radius_limits();
		test_width_shrink();
		test_backpressure();
		test_random_frames();
		drain();
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
